// ===== sv/lftc_pkg.sv =====
// shared types and constants for the line follow turn controller
package lftc_pkg;

  typedef enum logic [1:0] {
    MODE_FOLLOW = 2'd0,
    MODE_TURN   = 2'd1,
    MODE_STOP   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ACT_KEEP = 2'd0,
    ACT_SET  = 2'd1,
    ACT_STOP = 2'd2
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DECIDE,
    ST_PID,
    ST_DIFF,
    ST_OUT
  } state_t;

  localparam logic [2:0] REG_GAIN_P    = 3'd0;
  localparam logic [2:0] REG_GAIN_I    = 3'd1;
  localparam logic [2:0] REG_GAIN_D    = 3'd2;
  localparam logic [2:0] REG_BASE      = 3'd3;
  localparam logic [2:0] REG_WHITE     = 3'd4;
  localparam logic [2:0] REG_TIMEOUT   = 3'd5;
  localparam logic [2:0] REG_COOLDOWN  = 3'd6;
  localparam logic [2:0] REG_LIMIT     = 3'd7;

  localparam logic signed [7:0] ALL_BLACK_ERR = 8'sd30;

  function automatic logic signed [7:0] chan_weight(input logic [2:0] i);
    case (i)
      3'd0: chan_weight = -8'sd90;
      3'd1: chan_weight = -8'sd60;
      3'd2: chan_weight = -8'sd39;
      3'd3: chan_weight = -8'sd26;
      3'd4: chan_weight = 8'sd0;
      3'd5: chan_weight = 8'sd23;
      3'd6: chan_weight = 8'sd38;
      default: chan_weight = 8'sd90;
    endcase
  endfunction

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic decide;
    logic pid_mul;
    logic pid_diff;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic run_pid;
  } stat_t;

endpackage

// ===== sv/lftc_ctrl.sv =====
// sequencer for one control step
module lftc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  lftc_pkg::stat_t  stat,
  output lftc_pkg::cmd_t   cmd
);

  lftc_pkg::state_t state, state_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lftc_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      lftc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = lftc_pkg::ST_DIV;
        end
      end
      lftc_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = lftc_pkg::ST_DECIDE;
      end
      lftc_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = stat.run_pid ? lftc_pkg::ST_PID : lftc_pkg::ST_OUT;
      end
      lftc_pkg::ST_PID: begin
        cmd.pid_mul = 1'b1;
        state_next = lftc_pkg::ST_DIFF;
      end
      lftc_pkg::ST_DIFF: begin
        cmd.pid_diff = 1'b1;
        state_next = lftc_pkg::ST_OUT;
      end
      lftc_pkg::ST_OUT: begin
        // wait until the output register is free
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          out_valid_next = 1'b1;
          state_next = lftc_pkg::ST_IDLE;
        end
      end
      default: state_next = lftc_pkg::ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == lftc_pkg::ST_IDLE) else $error("ready outside idle");
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready)) else $error("result overwritten");
  a_load_div: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == lftc_pkg::ST_DIV) else $error("load not followed by divide");
`endif

endmodule

// ===== sv/lftc_dp.sv =====
// datapath: error mean, mode logic, pid and speed arithmetic
module lftc_dp #(
  parameter int MIN_TURN_MS  = 200,
  parameter int SPIN_SPEED   = 150,
  parameter bit COUNT_ENABLE = 1'b1
) (
  input  logic                clk,
  input  logic                rst,
  input  lftc_pkg::cmd_t      cmd,
  output lftc_pkg::stat_t     stat,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [7:0]          sensor_bits,
  input  logic [31:0]         now_ms,
  output logic signed [15:0]  left_speed,
  output logic signed [15:0]  right_speed,
  output logic [1:0]          motor_action,
  output logic [1:0]          mode_now,
  output logic                follow_flag,
  output logic                spin_flag,
  output logic [7:0]          turns_done
);

  logic [15:0] gain_p, gain_i, gain_d, white_wait_ms, turn_tmo, turn_gap;
  logic [10:0] base_speed;
  logic [7:0]  turn_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p <= 16'd256; gain_i <= 16'd0; gain_d <= 16'd0; base_speed <= 11'd200;
      white_wait_ms <= 16'd100; turn_tmo <= 16'd1000;
      turn_gap <= 16'd500; turn_limit <= 8'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        lftc_pkg::REG_GAIN_P:   gain_p <= cfg_data;
        lftc_pkg::REG_GAIN_I:   gain_i <= cfg_data;
        lftc_pkg::REG_GAIN_D:   gain_d <= cfg_data;
        lftc_pkg::REG_BASE:     base_speed <= cfg_data[10:0];
        lftc_pkg::REG_WHITE:    white_wait_ms <= cfg_data;
        lftc_pkg::REG_TIMEOUT:  turn_tmo <= cfg_data;
        lftc_pkg::REG_COOLDOWN: turn_gap <= cfg_data;
        lftc_pkg::REG_LIMIT:    turn_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // controller state
  lftc_pkg::mode_t mode;
  logic signed [1:0] last_sign;
  logic [31:0] white_since, turn_since, last_counted_at;
  logic [7:0]  turn_total;
  logic signed [31:0] error_sum;
  logic signed [7:0]  error_before;
  logic follow_mode, spin_mode, white_on, counted_ever, turn_counted;

  // step working registers
  logic [31:0] now_r;
  logic [3:0] cnt;
  logic signed [10:0] wsum;
  logic [9:0] mag;     // remainder of the divide
  logic [6:0] quot;
  logic [2:0] dstep;
  logic signed [7:0] err;
  logic signed [15:0] l_r, r_r;
  logic signed [32:0] p_prod, d_prod;
  logic signed [48:0] i_prod;
  logic signed [16:0] dval;
  logic run_pid_r;

  // weighted sum and count of black channels, combinational over eight channels
  logic signed [10:0] sum_c;
  logic [3:0] cnt_c;
  always_comb begin
    sum_c = '0;
    cnt_c = '0;
    for (int i = 0; i < 8; i++) begin
      if (!sensor_bits[i]) begin
        sum_c = sum_c + 11'(lftc_pkg::chan_weight(3'(i)));
        cnt_c = cnt_c + 4'd1;
      end
    end
  end

  // restoring divide of |sum| by count, one quotient bit per cycle
  logic [9:0] rem_sh;
  logic [9:0] trial;
  always_comb begin
    rem_sh = mag;
    trial = rem_sh - ({6'd0, cnt} << dstep);
  end

  // step decisions
  logic [31:0] el, since_cnt;
  logic tout, cool_ok, cnt_zero, cnt_exit;
  always_comb begin
    el = now_r - turn_since;
    since_cnt = now_r - last_counted_at;
    tout = el > {16'd0, turn_tmo};
    cool_ok = COUNT_ENABLE && (!counted_ever || since_cnt >= {16'd0, turn_gap});
    cnt_zero = cnt == 4'd0;
    cnt_exit = (cnt == 4'd1) || (cnt == 4'd2);
  end

  logic [7:0] total_inc;
  assign total_inc = (turn_total == 8'd255) ? turn_total : turn_total + 8'd1;

  logic signed [32:0] sum_ext;
  logic signed [31:0] sum_sat;
  logic signed [8:0]  err_diff;
  logic signed [63:0] acc, d_q;
  logic signed [16:0] d_clip;
  logic [16:0] d_mag;
  logic [32:0] tenth_prod;
  logic [13:0] tq;
  logic signed [14:0] d_tenth;
  logic signed [19:0] lw, rw;

  always_comb begin
    sum_ext = 33'(error_sum) + 33'(err);
    if (sum_ext > 33'sd2147483647) sum_sat = 32'h7fffffff;
    else if (sum_ext < -33'sd2147483648) sum_sat = 32'h80000000;
    else sum_sat = sum_ext[31:0];
    err_diff = 9'(err) - 9'(error_before);
    acc = 64'(p_prod) + 64'(i_prod) + 64'(d_prod);
    d_q = acc / 256;
    // beyond this range both wheel speeds saturate anyway
    if (d_q > 64'sd65535) d_clip = 17'h0ffff;
    else if (d_q < -64'sd65536) d_clip = 17'h10000;
    else d_clip = d_q[16:0];
    // right wheel subtracts d plus a tenth of d, the tenth truncated toward zero
    d_mag = dval[16] ? 17'(-dval) : 17'(dval);
    tenth_prod = 33'(d_mag) * 33'd52429;
    tq = tenth_prod[32:19];
    d_tenth = dval[16] ? -signed'({1'b0, tq}) : signed'({1'b0, tq});
    lw = 20'(signed'({1'b0, base_speed})) + 20'(dval);
    rw = 20'(signed'({1'b0, base_speed})) - 20'(dval) - 20'(d_tenth);
  end

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) sat16 = 16'sh7fff;
    else if (v < -20'sd32768) sat16 = 16'sh8000;
    else sat16 = v[15:0];
  endfunction

  logic run_pid;
  assign stat.div_done = dstep == 3'd0;
  assign stat.run_pid = run_pid;

  always_comb begin
    run_pid = 1'b0;
    if (mode == lftc_pkg::MODE_FOLLOW) run_pid = !cnt_zero;
    else if (mode == lftc_pkg::MODE_TURN)
      run_pid = (tout || cnt_exit) && !tout &&
                !(!turn_counted && el >= 32'(MIN_TURN_MS) && cool_ok &&
                  total_inc >= turn_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= lftc_pkg::MODE_FOLLOW;
      last_sign <= '0;
      white_since <= '0; turn_since <= '0; last_counted_at <= '0;
      turn_total <= '0; error_sum <= '0; error_before <= '0;
      follow_mode <= 1'b1; spin_mode <= 1'b0;
      white_on <= 1'b0; counted_ever <= 1'b0; turn_counted <= 1'b0;
      dstep <= '0;
    end else begin
      if (cmd.load) begin
        now_r <= now_ms;
        cnt <= cnt_c;
        wsum <= sum_c;
        mag <= sum_c[10] ? 10'(-sum_c) : sum_c[9:0];
        quot <= '0;
        dstep <= 3'd6;
      end
      if (cmd.div_step) begin
        if (!trial[9] && (rem_sh >= ({6'd0, cnt} << dstep))) begin
          mag <= trial;
          quot <= quot | (7'd1 << dstep);
        end
        if (dstep != 3'd0) dstep <= dstep - 3'd1;
      end
      if (cmd.decide) begin
        logic signed [7:0] e;
        logic signed [1:0] sg;
        logic won, tcnt;
        logic signed [15:0] lv, rv;
        lftc_pkg::act_t act;
        e = '0;
        sg = last_sign;
        won = white_on;
        tcnt = turn_counted;
        lv = '0;
        rv = '0;
        act = lftc_pkg::ACT_KEEP;
        if (!cnt_zero) begin
          e = wsum[10] ? -8'(quot) : 8'(quot);
          if (e > 0) sg = 2'sd1;
          if (e < 0) sg = -2'sd1;
          // all black follows the sign of this step's mean, or the last sign when the mean is zero
          if (cnt == 4'd8) e = (sg == 2'sd1) ? lftc_pkg::ALL_BLACK_ERR :
                              (sg == -2'sd1) ? -lftc_pkg::ALL_BLACK_ERR : 8'sd0;
        end
        err <= e;
        last_sign <= sg;
        case (mode)
          lftc_pkg::MODE_FOLLOW: begin
            if (cnt_zero) begin
              logic [31:0] ws;
              ws = white_on ? white_since : now_r;
              if (!white_on) begin won = 1'b1; white_since <= now_r; end
              if (now_r - ws >= {16'd0, white_wait_ms}) begin
                won = 1'b0;
                tcnt = 1'b0;
                if (cool_ok) begin
                  turn_total <= total_inc; last_counted_at <= now_r;
                  counted_ever <= 1'b1; tcnt = 1'b1;
                end
                if (cool_ok && total_inc >= turn_limit) begin
                  mode <= lftc_pkg::MODE_STOP; follow_mode <= 1'b0; spin_mode <= 1'b0;
                  act = lftc_pkg::ACT_STOP;
                end else begin
                  mode <= lftc_pkg::MODE_TURN; turn_since <= now_r;
                  follow_mode <= 1'b0; spin_mode <= 1'b1;
                  act = lftc_pkg::ACT_SET;
                  lv = -16'(SPIN_SPEED); rv = 16'(SPIN_SPEED);
                end
              end
            end else begin
              won = 1'b0; follow_mode <= 1'b1; spin_mode <= 1'b0;
              act = lftc_pkg::ACT_SET;
            end
          end
          lftc_pkg::MODE_TURN: begin
            if (tout || cnt_exit) begin
              logic try_cnt;
              try_cnt = !turn_counted && el >= 32'(MIN_TURN_MS) && cool_ok;
              if (try_cnt) begin
                turn_total <= total_inc; last_counted_at <= now_r;
                counted_ever <= 1'b1; tcnt = 1'b1;
              end
              if (try_cnt && total_inc >= turn_limit) begin
                mode <= lftc_pkg::MODE_STOP; follow_mode <= 1'b0; spin_mode <= 1'b0;
                act = lftc_pkg::ACT_STOP;
              end else begin
                mode <= lftc_pkg::MODE_FOLLOW; error_sum <= '0; won = 1'b0;
                spin_mode <= 1'b0; follow_mode <= 1'b1;
                if (tout) act = lftc_pkg::ACT_STOP;
                else act = lftc_pkg::ACT_SET;
              end
            end
          end
          default: begin
            mode <= lftc_pkg::MODE_STOP; follow_mode <= 1'b0; spin_mode <= 1'b0;
            act = lftc_pkg::ACT_STOP;
          end
        endcase
        white_on <= won;
        turn_counted <= tcnt;
        l_r <= lv;
        r_r <= rv;
        motor_action <= act;
      end
      if (cmd.pid_mul) begin
        // error_sum is already zero when entering from a turn exit
        error_sum <= sum_sat;
        p_prod <= signed'({1'b0, gain_p}) * 33'(err);
        i_prod <= signed'({1'b0, gain_i}) * 49'(sum_sat);
        d_prod <= signed'({1'b0, gain_d}) * 33'(err_diff);
        error_before <= err;
      end
      if (cmd.pid_diff) begin
        dval <= d_clip;
      end
      if (cmd.finish) begin
        left_speed <= (motor_action == lftc_pkg::ACT_SET) ?
                      (run_pid_r ? sat16(lw) : l_r) : 16'sd0;
        right_speed <= (motor_action == lftc_pkg::ACT_SET) ?
                       (run_pid_r ? sat16(rw) : r_r) : 16'sd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) run_pid_r <= 1'b0;
    else if (cmd.load) run_pid_r <= 1'b0;
    else if (cmd.pid_mul) run_pid_r <= 1'b1;
  end

  assign mode_now = mode;
  assign follow_flag = follow_mode;
  assign spin_flag = spin_mode;
  assign turns_done = turn_total;

`ifndef ASSERT_OFF
  a_stop_flags: assert property (@(posedge clk) disable iff (rst)
    mode == lftc_pkg::MODE_STOP |-> !follow_mode && !spin_mode) else $error("stopped flags");
  a_turn_spin: assert property (@(posedge clk) disable iff (rst)
    mode == lftc_pkg::MODE_TURN |-> spin_mode && !follow_mode) else $error("turn flags");
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> dstep == 3'd0) else $error("decide before divide done");
`endif

endmodule

// ===== sv/line_follow_turn_controller.sv =====
// top level of the line follow turn controller
//  channel   direction  handshake           payload
//  in        input      in_valid/in_ready   sensor_bits, now_ms
//  out       output     out_valid/out_ready left/right_speed, motor_action, mode, flags, turns
//  cfg       input      cfg_we              cfg_index, cfg_data
// accept to result valid: seven divide steps (one quotient bit each), decide, the pid
// multiply and difference states when the speed loop runs, then the output register.
// one request at a time; in_ready rises with out_valid.
// rst is synchronous and resets sequencer, config and mode state, not working or output registers.
// out_ready low holds the result; a new request still computes meanwhile.
module line_follow_turn_controller #(
  parameter int MIN_TURN_MS  = 200,
  parameter int SPIN_SPEED   = 150,
  parameter bit COUNT_ENABLE = 1'b1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         sensor_bits,
  input  logic [31:0]        now_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] left_speed,
  output logic signed [15:0] right_speed,
  output logic [1:0]         motor_action,
  output logic [1:0]         mode_now,
  output logic               follow_flag,
  output logic               spin_flag,
  output logic [7:0]         turns_done,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  lftc_pkg::cmd_t  cmd;
  lftc_pkg::stat_t stat;
  logic [1:0] act_w, mode_w;
  logic fl_w, sp_w;
  logic [7:0] tot_w;
  logic [1:0] act_q, mode_q;
  logic fl_q, sp_q;
  logic [7:0] tot_q;

  lftc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  lftc_dp #(
    .MIN_TURN_MS(MIN_TURN_MS), .SPIN_SPEED(SPIN_SPEED), .COUNT_ENABLE(COUNT_ENABLE)
  ) u_dp (
    .clk, .rst, .cmd, .stat, .cfg_we, .cfg_index, .cfg_data, .sensor_bits, .now_ms,
    .left_speed, .right_speed, .motor_action(act_w), .mode_now(mode_w),
    .follow_flag(fl_w), .spin_flag(sp_w), .turns_done(tot_w)
  );

  // status is captured with the speeds so that a held result stays put
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      act_q <= act_w; mode_q <= mode_w; fl_q <= fl_w; sp_q <= sp_w; tot_q <= tot_w;
    end
  end

  assign motor_action = act_q;
  assign mode_now = mode_q;
  assign follow_flag = fl_q;
  assign spin_flag = sp_q;
  assign turns_done = tot_q;

endmodule
